@@ rtl/pvkf_pkg.sv @@
// Shared constants, types and helpers for the position-velocity Kalman filter.
package pvkf_pkg;

  localparam int W      = 32;   // internal word width
  localparam int FRAC   = 16;   // fractional bits of Q16.16
  localparam int CFG_IW = 3;    // configuration index width
  localparam int STEP_W = 5;

  localparam logic signed [W-1:0] WMAX  = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMIN  = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] ONE_Q = W'(65536);
  localparam logic [30:0]         TENTH = 31'd6554;

  // Configuration register indexes
  localparam logic [CFG_IW-1:0] REG_INIT_POS   = 3'd0;
  localparam logic [CFG_IW-1:0] REG_INIT_VEL   = 3'd1;
  localparam logic [CFG_IW-1:0] REG_INIT_P_POS = 3'd2;
  localparam logic [CFG_IW-1:0] REG_INIT_P_VEL = 3'd3;
  localparam logic [CFG_IW-1:0] REG_Q_POS      = 3'd4;
  localparam logic [CFG_IW-1:0] REG_Q_VEL      = 3'd5;
  localparam logic [CFG_IW-1:0] REG_MEAS_NOISE = 3'd6;
  localparam logic [CFG_IW-1:0] REG_TIME_STEP  = 3'd7;

  typedef enum logic [2:0] {
    S_IDLE, S_PASS, S_MUL, S_ACC, S_DIV, S_DIVW, S_DONE
  } state_t;

  typedef enum logic [STEP_W-1:0] {
    ST_XP0, ST_FP00, ST_FP01, ST_PP00A, ST_PP00B, ST_PP10, ST_PP11, ST_Y, ST_S,
    ST_K0, ST_K1, ST_PE, ST_VE, ST_OMK0, ST_CPP, ST_CPV, ST_CVP, ST_CVV
  } step_t;

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_DONE} div_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
    mag = v[W-1] ? (~v + 1'b1) : v;
  endfunction

  // Saturate a (W+1)-bit sum to W bits.
  function automatic logic signed [W-1:0] sat_sum(input logic signed [W:0] v);
    if (v[W] != v[W-1]) sat_sum = v[W] ? WMIN : WMAX;
    else sat_sum = v[W-1:0];
  endfunction

endpackage

@@ rtl/pvkf_div.sv @@
// Serial restoring divider: Q16.16 quotient, truncated, saturated, zero on zero divisor.
module pvkf_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic signed [pvkf_pkg::W-1:0]   num,
  input  logic signed [pvkf_pkg::W-1:0]   den,
  output pvkf_pkg::div_stat_t             stat,
  output logic signed [pvkf_pkg::W-1:0]   quo
);

  localparam int W   = pvkf_pkg::W;
  localparam int PRE = W - 1 - pvkf_pkg::FRAC;

  pvkf_pkg::div_state_t state, state_next;

  logic [W-1:0]   rem;
  logic [W-2:0]   nlow;
  logic [W-2:0]   q;
  logic [4:0]     cnt;
  logic           neg;
  logic [W-1:0]   md;
  logic [W-1:0]   mn_in, md_in;
  logic           special;
  logic [W:0]     trial;
  logic           qbit;
  logic [W-1:0]   rem_next;
  logic [W-2:0]   q_next;

  assign mn_in   = pvkf_pkg::mag(num);
  assign md_in   = pvkf_pkg::mag(den);
  assign special = (md_in == '0) || ({{PRE{1'b0}}, mn_in} >= {md_in, {PRE{1'b0}}});

  assign trial    = {rem, nlow[W-2]} - {1'b0, md};
  assign qbit     = ~trial[W];
  assign rem_next = qbit ? trial[W-1:0] : {rem[W-2:0], nlow[W-2]};
  assign q_next   = {q[W-3:0], qbit};

  always_comb begin
    state_next = state;
    case (state)
      pvkf_pkg::D_IDLE: if (start) state_next = special ? pvkf_pkg::D_DONE : pvkf_pkg::D_RUN;
      pvkf_pkg::D_RUN:  if (cnt == '0) state_next = pvkf_pkg::D_DONE;
      pvkf_pkg::D_DONE: state_next = pvkf_pkg::D_IDLE;
      default:          state_next = pvkf_pkg::D_IDLE;
    endcase
  end

  always_comb begin
    stat.busy = 1'b0;
    stat.done = 1'b0;
    case (state)
      pvkf_pkg::D_RUN:  stat.busy = 1'b1;
      pvkf_pkg::D_DONE: stat.done = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pvkf_pkg::D_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == pvkf_pkg::D_IDLE && start) begin
      neg  <= num[W-1] ^ den[W-1];
      md   <= md_in;
      rem  <= W'(mn_in >> PRE);
      nlow <= {mn_in[PRE-1:0], {pvkf_pkg::FRAC{1'b0}}};
      q    <= '0;
      cnt  <= 5'(W - 2);
      if (md_in == '0) quo <= '0;
      else quo <= (num[W-1] ^ den[W-1]) ? pvkf_pkg::WMIN : pvkf_pkg::WMAX;
    end else if (state == pvkf_pkg::D_RUN) begin
      rem  <= rem_next;
      nlow <= {nlow[W-3:0], 1'b0};
      q    <= q_next;
      cnt  <= cnt - 1'b1;
      if (cnt == '0) quo <= neg ? -$signed({1'b0, q_next}) : $signed({1'b0, q_next});
    end
  end

  // Remainder stays below the divisor while iterating.
  a_rem_lt_md: assert property (@(posedge clk) disable iff (rst)
    state == pvkf_pkg::D_RUN |-> rem < md) else $error("divider remainder overflow");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    stat.done |=> !stat.done) else $error("divider done held");
  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    !(stat.busy && stat.done)) else $error("divider busy and done");

endmodule

@@ rtl/position_velocity_kalman_filter_top.sv @@
// Top level of the two-state position-velocity Kalman filter.
//
// Input channel (in_valid/in_ready): one request carries a Q16.16 position
// measurement and a restart flag. Restart reloads the estimate and
// covariance from the init registers, then the update runs.
// Before the first restart a request is passed through: position equals
// the measurement, velocity 0, filtered 0.
// Output channel (out_valid/out_ready): one result per request, held in an
// output register until taken.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always ready;
// write only while the block is idle.
// Sequence: a filtered request runs 18 micro-steps on one shared 32x32
// multiplier, adder and a serial divider: 11 multiply steps, 5 add steps
// and 2 divides (the divider skips its iterations when the divisor is
// zero or the quotient saturates), then the result is loaded into the
// output register. Most of the time is spent in the divider.
// in_ready is high only when the sequencer is idle, so a request is taken
// only once the previous one is done. A new request can be taken while the
// previous result still waits; if the receiver stalls, the next result
// waits in its last step until the output register frees.
// Reset (rst, synchronous) clears the state to zero, not started, and loads
// the register defaults.
module position_velocity_kalman_filter_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [31:0]                  measurement,
  input  logic                                restart,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [31:0]                  position,
  output logic signed [31:0]                  velocity,
  output logic                                filtered,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pvkf_pkg::CFG_IW-1:0]         cfg_index,
  input  logic [31:0]                         cfg_data
);

  localparam int W = pvkf_pkg::W;

  // config registers
  logic signed [31:0] init_pos, init_vel;
  logic [30:0]        init_p_pos, init_p_vel, q_pos, q_vel, meas_noise;
  logic [23:0]        time_step;

  // filter state
  logic signed [W-1:0] pe, ve, cpp, cpv, cvp, cvv;
  logic                started;

  // scratch
  logic signed [W-1:0] z, xp0, fp00, fp01, pp00, pp10, pp11, y, s, k0, k1;

  pvkf_pkg::state_t state, state_next;
  pvkf_pkg::step_t  step;

  logic [2*W-1:0]      prod;
  logic                pneg;
  logic signed [W-1:0] ua, ub, ux, uy;
  logic                usub;
  logic signed [W-1:0] dt_eff, r_eff, mres, acc_res;
  logic [2*W-pvkf_pkg::FRAC-1:0] pm;
  logic                pbig;
  logic                in_acc, out_free;
  logic                div_start;
  pvkf_pkg::div_stat_t div_stat;
  logic signed [W-1:0] div_quo;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == pvkf_pkg::S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  assign dt_eff = (time_step == '0) ? W'(pvkf_pkg::TENTH) : W'(time_step);
  assign r_eff  = (meas_noise == '0) ? W'(pvkf_pkg::TENTH) : W'(meas_noise);

  // micro-step operands: dst = x +/- (a*b or y)
  always_comb begin
    ua = '0; ub = '0; ux = '0; uy = '0; usub = 1'b0;
    case (step)
      pvkf_pkg::ST_XP0:   begin ua = dt_eff; ub = ve;  ux = pe;   end
      pvkf_pkg::ST_FP00:  begin ua = dt_eff; ub = cvp; ux = cpp;  end
      pvkf_pkg::ST_FP01:  begin ua = dt_eff; ub = cvv; ux = cpv;  end
      pvkf_pkg::ST_PP00A: begin ua = fp01; ub = dt_eff; ux = fp00; end
      pvkf_pkg::ST_PP00B: begin ux = pp00; uy = W'(q_pos); end
      pvkf_pkg::ST_PP10:  begin ua = cvv; ub = dt_eff; ux = cvp;  end
      pvkf_pkg::ST_PP11:  begin ux = cvv; uy = W'(q_vel); end
      pvkf_pkg::ST_Y:     begin ux = z; uy = xp0; usub = 1'b1; end
      pvkf_pkg::ST_S:     begin ux = pp00; uy = r_eff; end
      pvkf_pkg::ST_PE:    begin ua = k0; ub = y; ux = xp0; end
      pvkf_pkg::ST_VE:    begin ua = k1; ub = y; ux = ve;  end
      pvkf_pkg::ST_OMK0:  begin ux = pvkf_pkg::ONE_Q; uy = k0; usub = 1'b1; end
      pvkf_pkg::ST_CPP:   begin ua = k0; ub = pp00; end
      pvkf_pkg::ST_CPV:   begin ua = k0; ub = fp01; end
      pvkf_pkg::ST_CVP:   begin ua = k1; ub = pp00; ux = pp10; usub = 1'b1; end
      pvkf_pkg::ST_CVV:   begin ua = k1; ub = fp01; ux = pp11; usub = 1'b1; end
      default: ;
    endcase
  end

  function automatic logic is_mul(input pvkf_pkg::step_t st);
    case (st)
      pvkf_pkg::ST_PP00B, pvkf_pkg::ST_PP11, pvkf_pkg::ST_Y, pvkf_pkg::ST_S,
      pvkf_pkg::ST_OMK0, pvkf_pkg::ST_K0, pvkf_pkg::ST_K1: is_mul = 1'b0;
      default: is_mul = 1'b1;
    endcase
  endfunction

  function automatic pvkf_pkg::state_t step_entry(input pvkf_pkg::step_t st);
    if (st == pvkf_pkg::ST_K0 || st == pvkf_pkg::ST_K1) step_entry = pvkf_pkg::S_DIV;
    else if (is_mul(st)) step_entry = pvkf_pkg::S_MUL;
    else step_entry = pvkf_pkg::S_ACC;
  endfunction

  // product scale-down and saturation, then the shared add
  assign pm   = prod[2*W-1:pvkf_pkg::FRAC];
  assign pbig = |pm[2*W-pvkf_pkg::FRAC-1:W-1];
  always_comb begin
    logic signed [W-1:0] yv;
    logic signed [W:0]   sum;
    if (pbig) mres = pneg ? pvkf_pkg::WMIN : pvkf_pkg::WMAX;
    else mres = pneg ? -$signed(pm[W-1:0]) : $signed(pm[W-1:0]);
    yv  = is_mul(step) ? mres : uy;
    sum = usub ? ({ux[W-1], ux} - {yv[W-1], yv}) : ({ux[W-1], ux} + {yv[W-1], yv});
    acc_res = pvkf_pkg::sat_sum(sum);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      pvkf_pkg::S_IDLE:
        if (in_acc) begin
          if (restart || started) state_next = pvkf_pkg::S_MUL;
          else state_next = pvkf_pkg::S_PASS;
        end
      pvkf_pkg::S_PASS: if (out_free) state_next = pvkf_pkg::S_IDLE;
      pvkf_pkg::S_MUL:  state_next = pvkf_pkg::S_ACC;
      pvkf_pkg::S_ACC:
        if (step == pvkf_pkg::ST_CVV) state_next = pvkf_pkg::S_DONE;
        else state_next = step_entry(pvkf_pkg::step_t'(step + 1'b1));
      pvkf_pkg::S_DIV:  state_next = pvkf_pkg::S_DIVW;
      pvkf_pkg::S_DIVW:
        if (div_stat.done) state_next = step_entry(pvkf_pkg::step_t'(step + 1'b1));
      pvkf_pkg::S_DONE: if (out_free) state_next = pvkf_pkg::S_IDLE;
      default:          state_next = pvkf_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    div_start = 1'b0;
    case (state)
      pvkf_pkg::S_DIV: div_start = 1'b1;
      default: ;
    endcase
  end

  pvkf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   ((step == pvkf_pkg::ST_K0) ? pp00 : pp10),
    .den   (s),
    .stat  (div_stat),
    .quo   (div_quo)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= pvkf_pkg::S_IDLE;
      step       <= pvkf_pkg::ST_XP0;
      out_valid  <= 1'b0;
      started    <= 1'b0;
      init_pos   <= '0;
      init_vel   <= '0;
      init_p_pos <= 31'd65536;
      init_p_vel <= 31'd65536;
      q_pos      <= 31'd655;
      q_vel      <= 31'd655;
      meas_noise <= 31'd6554;
      time_step  <= 24'd6554;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          pvkf_pkg::REG_INIT_POS:   init_pos   <= cfg_data;
          pvkf_pkg::REG_INIT_VEL:   init_vel   <= cfg_data;
          pvkf_pkg::REG_INIT_P_POS: init_p_pos <= cfg_data[30:0];
          pvkf_pkg::REG_INIT_P_VEL: init_p_vel <= cfg_data[30:0];
          pvkf_pkg::REG_Q_POS:      q_pos      <= cfg_data[30:0];
          pvkf_pkg::REG_Q_VEL:      q_vel      <= cfg_data[30:0];
          pvkf_pkg::REG_MEAS_NOISE: meas_noise <= cfg_data[30:0];
          pvkf_pkg::REG_TIME_STEP:  time_step  <= cfg_data[23:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        step <= pvkf_pkg::ST_XP0;
        if (restart) started <= 1'b1;
      end else if ((state == pvkf_pkg::S_ACC && step != pvkf_pkg::ST_CVV) ||
                   (state == pvkf_pkg::S_DIVW && div_stat.done)) begin
        step <= pvkf_pkg::step_t'(step + 1'b1);
      end
      if ((state == pvkf_pkg::S_PASS || state == pvkf_pkg::S_DONE) && out_free)
        out_valid <= 1'b1;
      else if (out_ready)
        out_valid <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pe <= '0; ve <= '0; cpp <= '0; cpv <= '0; cvp <= '0; cvv <= '0;
    end else begin
      if (in_acc) begin
        z <= measurement;
        if (restart) begin
          pe  <= init_pos;
          ve  <= init_vel;
          cpp <= W'(init_p_pos);
          cpv <= '0;
          cvp <= '0;
          cvv <= W'(init_p_vel);
        end
      end
      if (state == pvkf_pkg::S_MUL) begin
        prod <= pvkf_pkg::mag(ua) * pvkf_pkg::mag(ub);
        pneg <= ua[W-1] ^ ub[W-1];
      end
      if (state == pvkf_pkg::S_ACC) begin
        case (step)
          pvkf_pkg::ST_XP0:   xp0  <= acc_res;
          pvkf_pkg::ST_FP00:  fp00 <= acc_res;
          pvkf_pkg::ST_FP01:  fp01 <= acc_res;
          pvkf_pkg::ST_PP00A: pp00 <= acc_res;
          pvkf_pkg::ST_PP00B: pp00 <= acc_res;
          pvkf_pkg::ST_PP10:  pp10 <= acc_res;
          pvkf_pkg::ST_PP11:  pp11 <= acc_res;
          pvkf_pkg::ST_Y:     y    <= acc_res;
          pvkf_pkg::ST_S:     s    <= acc_res;
          pvkf_pkg::ST_PE:    pe   <= acc_res;
          pvkf_pkg::ST_VE:    ve   <= acc_res;
          pvkf_pkg::ST_OMK0:  k0   <= acc_res;
          pvkf_pkg::ST_CPP:   cpp  <= acc_res;
          pvkf_pkg::ST_CPV:   cpv  <= acc_res;
          pvkf_pkg::ST_CVP:   cvp  <= acc_res;
          pvkf_pkg::ST_CVV:   cvv  <= acc_res;
          default: ;
        endcase
      end
      if (state == pvkf_pkg::S_DIVW && div_stat.done) begin
        if (step == pvkf_pkg::ST_K0) k0 <= div_quo;
        else k1 <= div_quo;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state == pvkf_pkg::S_PASS && out_free) begin
      position <= z;
      velocity <= '0;
      filtered <= 1'b0;
    end else if (state == pvkf_pkg::S_DONE && out_free) begin
      position <= pe[31:0];
      velocity <= ve[31:0];
      filtered <= 1'b1;
    end
  end

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> state == pvkf_pkg::S_DIVW) else $error("divider result unexpected");
  a_restart_starts: assert property (@(posedge clk) disable iff (rst)
    in_acc && restart |=> started) else $error("restart did not start filter");
  a_idle_div_quiet: assert property (@(posedge clk) disable iff (rst)
    state == pvkf_pkg::S_IDLE |-> !div_stat.busy) else $error("divider busy while idle");
  a_pass_only_unstarted: assert property (@(posedge clk) disable iff (rst)
    state == pvkf_pkg::S_PASS |-> !started) else $error("passthrough after start");

endmodule
